@@ src/cgc_pkg.sv @@
package cgc_pkg;

  // Status codes returned with every result word.
  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_PREC = 3'd1,
    ST_BLK  = 3'd2,
    ST_OVF  = 3'd3,
    ST_BAD  = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TILE_LEFT   = 3'd0,
    REG_TILE_TOP    = 3'd1,
    REG_TILE_RIGHT  = 3'd2,
    REG_TILE_BOTTOM = 3'd3,
    REG_NUM_RES     = 3'd4,
    REG_CBLK_W      = 3'd5,
    REG_CBLK_H      = 3'd6
  } cfg_reg_t;

  // Subband slot codes. Level 0 carries only LL; higher levels carry HL, LH, HH.
  localparam logic [1:0] BAND_LL = 2'd0;
  localparam logic [1:0] BAND_HL = 2'd0;
  localparam logic [1:0] BAND_LH = 2'd1;
  localparam logic [1:0] BAND_HH = 2'd2;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 4;

  // Classified query as it travels from the front to the back.
  typedef struct packed {
    logic       r0;
    logic [1:0] band;
    logic [3:0] pdx;
    logic [3:0] pdy;
    logic [5:0] lv;
    logic       bad;
  } cgc_ctl_t;

endpackage

@@ src/cgc_fifo.sv @@
module cgc_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = $clog2(cgc_pkg::QDEPTH);

  logic [DW-1:0] mem_r [cgc_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(cgc_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Storage array.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(cgc_pkg::QDEPTH))
    else $error("queue fill count beyond depth");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !push) |=> (cnt_r == $past(cnt_r) - (AW+1)'(1)))
    else $error("queue count did not drop on pop");

endmodule

@@ src/cgc_front.sv @@
module cgc_front #(
  parameter int INDEX_BITS = 16,
  parameter int MAX_LEVELS = 33
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [5:0]            in_resolution,
  input  logic [1:0]            in_subband,
  input  logic [3:0]            in_precinct_exp_w,
  input  logic [3:0]            in_precinct_exp_h,
  input  logic [INDEX_BITS-1:0] in_precinct_index,
  input  logic [INDEX_BITS-1:0] in_codeblock_index,
  input  logic [5:0]            num_res,
  input  logic                  q_full,
  output logic                  q_push,
  output cgc_pkg::cgc_ctl_t     q_ctl,
  output logic [INDEX_BITS-1:0] q_pi,
  output logic [INDEX_BITS-1:0] q_ci
);

  logic                  v_r;
  cgc_pkg::cgc_ctl_t     ctl_r, ctl_nxt;
  logic [INDEX_BITS-1:0] pi_r, ci_r;
  logic [5:0]            n;

  // Classify the query: level count, band legality, exponents, level depth.
  always_comb begin
    n = (num_res > 6'(MAX_LEVELS)) ? 6'(MAX_LEVELS) : num_res;
    ctl_nxt.r0   = (in_resolution == 6'd0);
    ctl_nxt.band = in_subband;
    ctl_nxt.pdx  = in_precinct_exp_w;
    ctl_nxt.pdy  = in_precinct_exp_h;
    ctl_nxt.lv   = n - 6'd1 - in_resolution;
    ctl_nxt.bad  = (in_resolution >= n) ||
                   (ctl_nxt.r0 ? (in_subband != cgc_pkg::BAND_LL)
                               : (in_subband > cgc_pkg::BAND_HH)) ||
                   (!ctl_nxt.r0 && (in_precinct_exp_w == 4'd0 ||
                                    in_precinct_exp_h == 4'd0));
  end

  assign in_ready = !v_r || !q_full;
  assign q_push   = v_r;
  assign q_ctl    = ctl_r;
  assign q_pi     = pi_r;
  assign q_ci     = ci_r;

  // Holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctl_r <= ctl_nxt;
      pi_r  <= in_precinct_index;
      ci_r  <= in_codeblock_index;
    end
  end

endmodule

@@ src/cgc_div.sv @@
module cgc_div #(
  parameter int IB = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [IB-1:0] in_dvd,
  input  logic [IB:0]   in_dvs,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [IB-1:0] out_quo,
  output logic [IB-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  logic [IB-1:0] n_r [IB];
  logic [IB-1:0] r_r [IB];
  logic [IB:0]   d_r [IB];
  logic [SW-1:0] s_r [IB];
  logic [IB-1:0] n_nxt [IB];
  logic [IB-1:0] r_nxt [IB];
  logic          v_r [IB];

  // One quotient bit per stage, restoring compare and subtract.
  always_comb begin
    logic [IB-1:0] nn, rr;
    logic [IB:0]   dd, tr;
    logic          ge;
    for (int k = 0; k < IB; k++) begin
      nn = (k == 0) ? in_dvd : n_r[(k == 0) ? 0 : k-1];
      rr = (k == 0) ? '0 : r_r[(k == 0) ? 0 : k-1];
      dd = (k == 0) ? in_dvs : d_r[(k == 0) ? 0 : k-1];
      tr = {rr, nn[IB-1]};
      ge = (tr >= dd);
      n_nxt[k] = {nn[IB-2:0], ge};
      r_nxt[k] = ge ? IB'(tr - dd) : IB'(tr);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < IB; k++) begin
        n_r[k] <= n_nxt[k];
        r_r[k] <= r_nxt[k];
        d_r[k] <= (k == 0) ? in_dvs : d_r[(k == 0) ? 0 : k-1];
        s_r[k] <= (k == 0) ? in_side : s_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < IB; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < IB; k++) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = v_r[IB-1];
  assign out_quo   = n_r[IB-1];
  assign out_rem   = r_r[IB-1];
  assign out_side  = s_r[IB-1];

endmodule

@@ src/cgc_back.sv @@
module cgc_back #(
  parameter int COORD_BITS = 32,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  cgc_pkg::cgc_ctl_t     q_ctl,
  input  logic [INDEX_BITS-1:0] q_pi,
  input  logic [INDEX_BITS-1:0] q_ci,
  input  logic [COORD_BITS-1:0] tile_left,
  input  logic [COORD_BITS-1:0] tile_top,
  input  logic [COORD_BITS-1:0] tile_right,
  input  logic [COORD_BITS-1:0] tile_bottom,
  input  logic [3:0]            cblk_w_exp,
  input  logic [3:0]            cblk_h_exp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_block_left,
  output logic [31:0]           out_block_top,
  output logic [31:0]           out_block_right,
  output logic [31:0]           out_block_bottom,
  output logic [15:0]           out_precincts_wide,
  output logic [15:0]           out_precincts_high,
  output logic [15:0]           out_blocks_wide,
  output logic [15:0]           out_blocks_high,
  output logic [2:0]            out_status
);

  localparam int W       = COORD_BITS;
  localparam int W1      = W + 1;
  localparam int V       = W + 2;
  localparam int IB      = INDEX_BITS;
  localparam int PW      = IB + 1;
  localparam int SH      = IB + 16;
  localparam int NP      = 17;
  localparam int CNT_LIM = (IB >= 16) ? 65535 : ((1 << IB) - 1);

  typedef struct packed {
    cgc_pkg::status_t st;
    logic             r0;
    logic [1:0]       band;
    logic [3:0]       pdx, pdy, gew, geh, ew, eh;
    logic [5:0]       lv;
    logic [IB-1:0]    pi, ci, q, rm;
    logic [V-1:0]     rx0, ry0, rx1, ry1;
    logic [W-1:0]     dx0, dy0, dx1, dy1;
    logic [3:0]       neg;
    logic [V-1:0]     bx0, by0, bx1, by1, psx, psy, pex, pey;
    logic             ex, ey;
    logic [V-1:0]     pw, ph, gx, gy;
    logic [PW-1:0]    pwc, phc, cwc, chc;
    logic [2*PW-1:0]  prod;
    logic [V-1:0]     cgx0, cgy0, cex, cey, prx0, pry0, prx1, pry1;
    logic [V-1:0]     cax, cay, cbx, cby;
    logic             emx, emy;
    logic [V-1:0]     cw, ch, blx, bly, bex, bey, brx, bry;
  } rec_t;

  rec_t         p_r [NP];
  rec_t         p_nxt [NP];
  logic [NP-1:0] v_r, v_nxt;
  logic         adv;
  logic         d1_v, d2_v;
  logic [IB-1:0] d1_q, d1_rm, d2_q, d2_rm;
  rec_t         d1_side, d2_side;

  logic         out_valid_r;
  logic [31:0]  bl_r, bt_r, br_r, bb_r;
  logic [15:0]  pw_out_r, ph_out_r, cw_out_r, ch_out_r;
  logic [2:0]   st_r;

  function automatic logic [V-1:0] msk(input logic [5:0] s);
    logic [V-1:0] m;
    if (s >= 6'(V)) begin
      m = '1;
    end else begin
      m = (V'(1) << s) - V'(1);
    end
    return m;
  endfunction

  // Right shift rounding up.
  function automatic logic [V-1:0] csh(input logic [V-1:0] v, input logic [5:0] s);
    logic [V-1:0] q;
    q = (s >= 6'(V)) ? '0 : (v >> s);
    return q + V'(|(v & msk(s)));
  endfunction

  // Tile edge minus the band offset; the top bit flags a result below zero.
  function automatic logic [W:0] bdiff(input logic [W-1:0] t, input logic ap,
                                       input logic [5:0] lv);
    logic [W:0] off, dif;
    off = (ap && lv < 6'(W)) ? (W1'(1) << lv) : '0;
    dif = {1'b0, t} - off;
    return {ap && (lv >= 6'(W) || dif[W]), dif[W-1:0]};
  endfunction

  function automatic logic [PW-1:0] clampc(input logic [V-1:0] c);
    return (|(c >> IB)) ? (PW'(1) << IB) : PW'(c);
  endfunction

  function automatic logic [15:0] sat(input logic [PW-1:0] c);
    return (c > PW'(CNT_LIM)) ? 16'(CNT_LIM) : 16'(c);
  endfunction

  function automatic logic [V-1:0] vmax(input logic [V-1:0] a, input logic [V-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [V-1:0] vmin(input logic [V-1:0] a, input logic [V-1:0] b);
    return (a < b) ? a : b;
  endfunction

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  // Pipeline stage logic.
  always_comb begin
    logic       apx, apy;
    logic [W:0] t0, t1, t2, t3;
    for (int k = 1; k < NP; k++) begin
      p_nxt[k] = p_r[k-1];
    end
    p_nxt[0] = '0;

    // Resolution rectangle, band differences and exponents.
    apx = !q_ctl.r0 && (q_ctl.band != cgc_pkg::BAND_LH);
    apy = !q_ctl.r0 && (q_ctl.band != cgc_pkg::BAND_HL);
    t0 = bdiff(tile_left, apx, q_ctl.lv);
    t1 = bdiff(tile_top, apy, q_ctl.lv);
    t2 = bdiff(tile_right, apx, q_ctl.lv);
    t3 = bdiff(tile_bottom, apy, q_ctl.lv);
    p_nxt[0].st   = q_ctl.bad ? cgc_pkg::ST_BAD : cgc_pkg::ST_OK;
    p_nxt[0].r0   = q_ctl.r0;
    p_nxt[0].band = q_ctl.band;
    p_nxt[0].pdx  = q_ctl.pdx;
    p_nxt[0].pdy  = q_ctl.pdy;
    p_nxt[0].lv   = q_ctl.lv;
    p_nxt[0].pi   = q_pi;
    p_nxt[0].ci   = q_ci;
    p_nxt[0].rx0  = csh(V'(tile_left), q_ctl.lv);
    p_nxt[0].ry0  = csh(V'(tile_top), q_ctl.lv);
    p_nxt[0].rx1  = csh(V'(tile_right), q_ctl.lv);
    p_nxt[0].ry1  = csh(V'(tile_bottom), q_ctl.lv);
    p_nxt[0].dx0  = t0[W-1:0];
    p_nxt[0].dy0  = t1[W-1:0];
    p_nxt[0].dx1  = t2[W-1:0];
    p_nxt[0].dy1  = t3[W-1:0];
    p_nxt[0].neg  = {t3[W], t2[W], t1[W], t0[W]};
    p_nxt[0].gew  = q_ctl.r0 ? q_ctl.pdx : q_ctl.pdx - 4'd1;
    p_nxt[0].geh  = q_ctl.r0 ? q_ctl.pdy : q_ctl.pdy - 4'd1;
    p_nxt[0].ew   = (cblk_w_exp < p_nxt[0].gew) ? cblk_w_exp : p_nxt[0].gew;
    p_nxt[0].eh   = (cblk_h_exp < p_nxt[0].geh) ? cblk_h_exp : p_nxt[0].geh;

    // Band rectangle and precinct grid ends.
    p_nxt[1].bx0 = p_r[0].r0 ? p_r[0].rx0 :
                   (p_r[0].neg[0] ? '0 : csh(V'(p_r[0].dx0), p_r[0].lv + 6'd1));
    p_nxt[1].by0 = p_r[0].r0 ? p_r[0].ry0 :
                   (p_r[0].neg[1] ? '0 : csh(V'(p_r[0].dy0), p_r[0].lv + 6'd1));
    p_nxt[1].bx1 = p_r[0].r0 ? p_r[0].rx1 :
                   (p_r[0].neg[2] ? '0 : csh(V'(p_r[0].dx1), p_r[0].lv + 6'd1));
    p_nxt[1].by1 = p_r[0].r0 ? p_r[0].ry1 :
                   (p_r[0].neg[3] ? '0 : csh(V'(p_r[0].dy1), p_r[0].lv + 6'd1));
    p_nxt[1].psx = p_r[0].rx0 & ~msk({2'b00, p_r[0].pdx});
    p_nxt[1].psy = p_r[0].ry0 & ~msk({2'b00, p_r[0].pdy});
    p_nxt[1].pex = (p_r[0].rx1 + msk({2'b00, p_r[0].pdx})) & ~msk({2'b00, p_r[0].pdx});
    p_nxt[1].pey = (p_r[0].ry1 + msk({2'b00, p_r[0].pdy})) & ~msk({2'b00, p_r[0].pdy});
    p_nxt[1].ex  = (p_r[0].rx0 >= p_r[0].rx1);
    p_nxt[1].ey  = (p_r[0].ry0 >= p_r[0].ry1);

    // Overflow check, precinct counts and grid origin in the band.
    if (p_r[1].st == cgc_pkg::ST_OK && ((|(p_r[1].pex >> W)) || (|(p_r[1].pey >> W)))) begin
      p_nxt[2].st = cgc_pkg::ST_OVF;
    end
    p_nxt[2].pw = p_r[1].ex ? '0 : ((p_r[1].pex - p_r[1].psx) >> p_r[1].pdx);
    p_nxt[2].ph = p_r[1].ey ? '0 : ((p_r[1].pey - p_r[1].psy) >> p_r[1].pdy);
    p_nxt[2].gx = p_r[1].r0 ? p_r[1].psx : csh(p_r[1].psx, 6'd1);
    p_nxt[2].gy = p_r[1].r0 ? p_r[1].psy : csh(p_r[1].psy, 6'd1);

    // Counts clamped just past the index range, then their product.
    p_nxt[3].pwc  = clampc(p_r[2].pw);
    p_nxt[3].phc  = clampc(p_r[2].ph);
    p_nxt[4].prod = (2*PW)'(p_r[3].pwc) * (2*PW)'(p_r[3].phc);
    if (p_r[4].st == cgc_pkg::ST_OK && (2*PW)'(p_r[4].pi) >= p_r[4].prod) begin
      p_nxt[5].st = cgc_pkg::ST_PREC;
    end

    // Precinct origin from column and row of the precinct index.
    p_nxt[6]      = d1_side;
    p_nxt[6].q    = d1_q;
    p_nxt[6].rm   = d1_rm;
    p_nxt[6].cgx0 = d1_side.gx + V'(SH'(d1_rm) << d1_side.gew);
    p_nxt[6].cgy0 = d1_side.gy + V'(SH'(d1_q) << d1_side.geh);

    // Precinct rectangle clipped to the band.
    p_nxt[7].cex  = p_r[6].cgx0 + (V'(1) << p_r[6].gew);
    p_nxt[7].cey  = p_r[6].cgy0 + (V'(1) << p_r[6].geh);
    p_nxt[7].prx0 = vmax(p_r[6].cgx0, p_r[6].bx0);
    p_nxt[7].pry0 = vmax(p_r[6].cgy0, p_r[6].by0);
    p_nxt[8].prx1 = vmin(p_r[7].cex, p_r[7].bx1);
    p_nxt[8].pry1 = vmin(p_r[7].cey, p_r[7].by1);

    // Code-block counts inside the precinct.
    p_nxt[9].cax = csh(p_r[8].prx1, {2'b00, p_r[8].ew});
    p_nxt[9].cay = csh(p_r[8].pry1, {2'b00, p_r[8].eh});
    p_nxt[9].cbx = p_r[8].prx0 >> p_r[8].ew;
    p_nxt[9].cby = p_r[8].pry0 >> p_r[8].eh;
    p_nxt[9].emx = (p_r[8].prx0 >= p_r[8].prx1);
    p_nxt[9].emy = (p_r[8].pry0 >= p_r[8].pry1);
    p_nxt[10].cw = p_r[9].emx ? '0 : (p_r[9].cax - p_r[9].cbx);
    p_nxt[10].ch = p_r[9].emy ? '0 : (p_r[9].cay - p_r[9].cby);
    p_nxt[11].cwc = clampc(p_r[10].cw);
    p_nxt[11].chc = clampc(p_r[10].ch);
    p_nxt[12].prod = (2*PW)'(p_r[11].cwc) * (2*PW)'(p_r[11].chc);
    if (p_r[12].st == cgc_pkg::ST_OK && (2*PW)'(p_r[12].ci) >= p_r[12].prod) begin
      p_nxt[13].st = cgc_pkg::ST_BLK;
    end

    // Code-block origin from column and row of the block index.
    p_nxt[14]     = d2_side;
    p_nxt[14].q   = d2_q;
    p_nxt[14].rm  = d2_rm;
    p_nxt[14].blx = (d2_side.prx0 & ~msk({2'b00, d2_side.ew})) +
                    V'(SH'(d2_rm) << d2_side.ew);
    p_nxt[14].bly = (d2_side.pry0 & ~msk({2'b00, d2_side.eh})) +
                    V'(SH'(d2_q) << d2_side.eh);

    // Code-block rectangle clipped to the precinct.
    p_nxt[15].bex = p_r[14].blx + (V'(1) << p_r[14].ew);
    p_nxt[15].bey = p_r[14].bly + (V'(1) << p_r[14].eh);
    p_nxt[16].brx = vmin(p_r[15].bex, p_r[15].prx1);
    p_nxt[16].bry = vmin(p_r[15].bey, p_r[15].pry1);
    p_nxt[16].blx = vmax(p_r[15].blx, p_r[15].prx0);
    p_nxt[16].bly = vmax(p_r[15].bly, p_r[15].pry0);
  end

  always_comb begin
    v_nxt[0] = q_pop;
    for (int k = 1; k < NP; k++) begin
      v_nxt[k] = v_r[k-1];
    end
    v_nxt[6]  = d1_v;
    v_nxt[14] = d2_v;
  end

  // Precinct index split into column and row.
  cgc_div #(.IB(IB), .SW($bits(rec_t))) u_div_prec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v_r[5]),
    .in_dvd   (p_r[5].pi),
    .in_dvs   (p_r[5].pwc),
    .in_side  (p_r[5]),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_rem  (d1_rm),
    .out_side (d1_side)
  );

  // Block index split into column and row.
  cgc_div #(.IB(IB), .SW($bits(rec_t))) u_div_blk (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v_r[13]),
    .in_dvd   (p_r[13].ci),
    .in_dvs   (p_r[13].cwc),
    .in_side  (p_r[13]),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_rem  (d2_rm),
    .out_side (d2_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NP; k++) begin
        p_r[k] <= p_nxt[k];
      end
    end
  end

  // Output register: fields not covered by the status read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= p_r[NP-1].st;
      if (p_r[NP-1].st == cgc_pkg::ST_OK || p_r[NP-1].st == cgc_pkg::ST_PREC ||
          p_r[NP-1].st == cgc_pkg::ST_BLK) begin
        pw_out_r <= sat(p_r[NP-1].pwc);
        ph_out_r <= sat(p_r[NP-1].phc);
      end else begin
        pw_out_r <= '0;
        ph_out_r <= '0;
      end
      if (p_r[NP-1].st == cgc_pkg::ST_OK || p_r[NP-1].st == cgc_pkg::ST_BLK) begin
        cw_out_r <= sat(p_r[NP-1].cwc);
        ch_out_r <= sat(p_r[NP-1].chc);
      end else begin
        cw_out_r <= '0;
        ch_out_r <= '0;
      end
      if (p_r[NP-1].st == cgc_pkg::ST_OK) begin
        bl_r <= 32'(p_r[NP-1].blx);
        bt_r <= 32'(p_r[NP-1].bly);
        br_r <= 32'(p_r[NP-1].brx);
        bb_r <= 32'(p_r[NP-1].bry);
      end else begin
        bl_r <= '0;
        bt_r <= '0;
        br_r <= '0;
        bb_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_block_left     = bl_r;
  assign out_block_top      = bt_r;
  assign out_block_right    = br_r;
  assign out_block_bottom   = bb_r;
  assign out_precincts_wide = pw_out_r;
  assign out_precincts_high = ph_out_r;
  assign out_blocks_wide    = cw_out_r;
  assign out_blocks_high    = ch_out_r;
  assign out_status         = st_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (st_r == cgc_pkg::ST_BAD || st_r == cgc_pkg::ST_OVF)) |->
    (pw_out_r == '0 && ph_out_r == '0 && cw_out_r == '0 && bl_r == '0))
    else $error("rejected word carries nonzero fields");

  a_ok_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r == cgc_pkg::ST_OK) |->
    (cw_out_r != '0 && ch_out_r != '0 && pw_out_r != '0))
    else $error("accepted word with an empty grid");

  a_prec_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r == cgc_pkg::ST_PREC) |-> (cw_out_r == '0 && br_r == '0))
    else $error("precinct miss carries block data");

endmodule

@@ src/codeblock_geometry_calculator.sv @@
// Code-block geometry lookup for one tile component.
// Configuration: write tile_left/top/right/bottom, num_resolutions and the
// nominal code-block exponents through cfg_wr_en, cfg_index and cfg_wdata
// while no query is in flight. Writes take effect at the next clock.
// Input channel (in_valid/in_ready): one word per query with the level,
// subband slot, precinct exponents, precinct index and code-block index.
// Output channel (out_valid/out_ready): one word per query with the
// code-block rectangle, both grid sizes and a status code, in order.
// The path is a front register, the queue, the back pipeline with two
// INDEX_BITS-stage dividers that split the precinct and block indexes,
// and the output register. A new word is taken every cycle while the
// output is not stalled.
// Reset clears all valid state and loads the register reset values.
// When out_ready is low the back pipeline holds; the four-word queue and
// the front register keep taking words until they fill, then in_ready drops.
module codeblock_geometry_calculator #(
  parameter int COORD_BITS = 32,
  parameter int INDEX_BITS = 16,
  parameter int MAX_LEVELS = 33
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [5:0]            in_resolution,
  input  logic [1:0]            in_subband,
  input  logic [3:0]            in_precinct_exp_w,
  input  logic [3:0]            in_precinct_exp_h,
  input  logic [INDEX_BITS-1:0] in_precinct_index,
  input  logic [INDEX_BITS-1:0] in_codeblock_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_block_left,
  output logic [31:0]           out_block_top,
  output logic [31:0]           out_block_right,
  output logic [31:0]           out_block_bottom,
  output logic [15:0]           out_precincts_wide,
  output logic [15:0]           out_precincts_high,
  output logic [15:0]           out_blocks_wide,
  output logic [15:0]           out_blocks_high,
  output logic [2:0]            out_status
);

  localparam int QW = $bits(cgc_pkg::cgc_ctl_t) + 2 * INDEX_BITS;

  logic [COORD_BITS-1:0] tile_left_r, tile_top_r, tile_right_r, tile_bottom_r;
  logic [5:0]            num_res_r;
  logic [3:0]            cblk_w_r, cblk_h_r;

  logic                  q_push, q_pop, q_full, q_empty;
  cgc_pkg::cgc_ctl_t     f_ctl, b_ctl;
  logic [INDEX_BITS-1:0] f_pi, f_ci, b_pi, b_ci;
  logic [QW-1:0]         q_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_left_r   <= '0;
      tile_top_r    <= '0;
      tile_right_r  <= '0;
      tile_bottom_r <= '0;
      num_res_r     <= 6'd6;
      cblk_w_r      <= 4'd6;
      cblk_h_r      <= 4'd6;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cgc_pkg::REG_TILE_LEFT:   tile_left_r   <= cfg_wdata;
        cgc_pkg::REG_TILE_TOP:    tile_top_r    <= cfg_wdata;
        cgc_pkg::REG_TILE_RIGHT:  tile_right_r  <= cfg_wdata;
        cgc_pkg::REG_TILE_BOTTOM: tile_bottom_r <= cfg_wdata;
        cgc_pkg::REG_NUM_RES:     num_res_r     <= cfg_wdata[5:0];
        cgc_pkg::REG_CBLK_W:      cblk_w_r      <= cfg_wdata[3:0];
        cgc_pkg::REG_CBLK_H:      cblk_h_r      <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  cgc_front #(.INDEX_BITS(INDEX_BITS), .MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_resolution     (in_resolution),
    .in_subband        (in_subband),
    .in_precinct_exp_w (in_precinct_exp_w),
    .in_precinct_exp_h (in_precinct_exp_h),
    .in_precinct_index (in_precinct_index),
    .in_codeblock_index(in_codeblock_index),
    .num_res           (num_res_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_ctl             (f_ctl),
    .q_pi              (f_pi),
    .q_ci              (f_ci)
  );

  cgc_fifo #(.DW(QW)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({f_ctl, f_pi, f_ci}),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  assign {b_ctl, b_pi, b_ci} = q_rdata;

  cgc_back #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_ctl             (b_ctl),
    .q_pi              (b_pi),
    .q_ci              (b_ci),
    .tile_left         (tile_left_r),
    .tile_top          (tile_top_r),
    .tile_right        (tile_right_r),
    .tile_bottom       (tile_bottom_r),
    .cblk_w_exp        (cblk_w_r),
    .cblk_h_exp        (cblk_h_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block_left    (out_block_left),
    .out_block_top     (out_block_top),
    .out_block_right   (out_block_right),
    .out_block_bottom  (out_block_bottom),
    .out_precincts_wide(out_precincts_wide),
    .out_precincts_high(out_precincts_high),
    .out_blocks_wide   (out_blocks_wide),
    .out_blocks_high   (out_blocks_high),
    .out_status        (out_status)
  );

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_RANDOM = 1300;
  localparam int LATENCY = 51;

  // One query word as it goes into the block.
  typedef struct {
    logic [5:0]  res;
    logic [1:0]  band;
    logic [3:0]  pw_exp;
    logic [3:0]  ph_exp;
    logic [15:0] prec;
    logic [15:0] cblk;
  } query_t;

  // One geometry word as it comes out of the block.
  typedef struct {
    logic [31:0] x0;
    logic [31:0] y0;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [15:0] pcols;
    logic [15:0] prows;
    logic [15:0] bcols;
    logic [15:0] brows;
    logic [2:0]  st;
  } geom_t;

  // One directed row; a typed-in result is used when has_fixed is set.
  typedef struct {
    query_t q;
    bit     has_fixed;
    geom_t  fixed;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [5:0]  in_resolution;
  logic [1:0]  in_subband;
  logic [3:0]  in_precinct_exp_w;
  logic [3:0]  in_precinct_exp_h;
  logic [15:0] in_precinct_index;
  logic [15:0] in_codeblock_index;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_block_left;
  logic [31:0] out_block_top;
  logic [31:0] out_block_right;
  logic [31:0] out_block_bottom;
  logic [15:0] out_precincts_wide;
  logic [15:0] out_precincts_high;
  logic [15:0] out_blocks_wide;
  logic [15:0] out_blocks_high;
  logic [2:0]  out_status;

  codeblock_geometry_calculator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_resolution(in_resolution), .in_subband(in_subband),
    .in_precinct_exp_w(in_precinct_exp_w), .in_precinct_exp_h(in_precinct_exp_h),
    .in_precinct_index(in_precinct_index), .in_codeblock_index(in_codeblock_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_block_left(out_block_left), .out_block_top(out_block_top),
    .out_block_right(out_block_right), .out_block_bottom(out_block_bottom),
    .out_precincts_wide(out_precincts_wide), .out_precincts_high(out_precincts_high),
    .out_blocks_wide(out_blocks_wide), .out_blocks_high(out_blocks_high),
    .out_status(out_status)
  );

  // Shadow copy of the configuration registers.
  logic [63:0] t_left, t_top, t_right, t_bottom;
  int unsigned levels, cb_wexp, cb_hexp;

  geom_t  pending_geom[$];
  int     mismatches;
  int     cycle_count;
  bit     quiet_phase;
  bit     hold_recv;
  int     hold_cycles;
  int     rx_idle;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] up_shift(logic [63:0] v, int unsigned s);
    return (v + ((64'd1 << s) - 64'd1)) >> s;
  endfunction

  function automatic logic [63:0] band_edge(logic [63:0] t, logic [63:0] off,
                                            int unsigned s);
    // Band offset larger than the tile origin clamps the edge to zero.
    if ($signed(t) - $signed(off) <= 0) return 64'd0;
    return up_shift(t - off, s);
  endfunction

  function automatic logic [15:0] clamp16(logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [63:0] max64(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a : b;
  endfunction

  // Computes the code-block geometry for one query from the shadow registers.
  function automatic geom_t block_geometry(query_t q);
    geom_t g;
    int unsigned n, lv, gew, geh, ew, eh, r, b, pdx, pdy;
    logic [63:0] rx0, ry0, rx1, ry1, psx, psy, pex, pey, pw, ph;
    logic [63:0] bx0, by0, bx1, by1, gx, gy, cgx0, cgy0, ox, oy;
    logic [63:0] prx0, pry0, prx1, pry1, cw, ch, blx, bly, brx, bry;
    g = '{default: '0};
    g.st = cgc_pkg::ST_OK;
    r = 32'(q.res); b = 32'(q.band); pdx = 32'(q.pw_exp); pdy = 32'(q.ph_exp);
    n = (levels > 33) ? 33 : levels;
    if (r >= n || (r == 0 ? b != 0 : b > 2) || (r > 0 && (pdx == 0 || pdy == 0))) begin
      g.st = cgc_pkg::ST_BAD;
      return g;
    end
    lv = n - 1 - r;
    rx0 = up_shift(t_left, lv);
    ry0 = up_shift(t_top, lv);
    rx1 = up_shift(t_right, lv);
    ry1 = up_shift(t_bottom, lv);
    psx = (rx0 >> pdx) << pdx;
    psy = (ry0 >> pdy) << pdy;
    pex = up_shift(rx1, pdx) << pdx;
    pey = up_shift(ry1, pdy) << pdy;
    if (pex > 64'hFFFF_FFFF || pey > 64'hFFFF_FFFF) begin
      g.st = cgc_pkg::ST_OVF;
      return g;
    end
    pw = (rx0 >= rx1) ? 64'd0 : ((pex - psx) >> pdx);
    ph = (ry0 >= ry1) ? 64'd0 : ((pey - psy) >> pdy);
    g.pcols = clamp16(pw);
    g.prows = clamp16(ph);
    if (64'(q.prec) >= pw * ph) begin
      g.st = cgc_pkg::ST_PREC;
      return g;
    end
    if (r == 0) begin
      bx0 = rx0; by0 = ry0; bx1 = rx1; by1 = ry1;
      gx = psx; gy = psy; gew = pdx; geh = pdy;
    end else begin
      ox = 64'((b + 1) & 1) << lv;
      oy = 64'((b + 1) >> 1) << lv;
      bx0 = band_edge(t_left, ox, lv + 1);
      by0 = band_edge(t_top, oy, lv + 1);
      bx1 = band_edge(t_right, ox, lv + 1);
      by1 = band_edge(t_bottom, oy, lv + 1);
      gx = up_shift(psx, 1);
      gy = up_shift(psy, 1);
      gew = pdx - 1; geh = pdy - 1;
    end
    ew = (cb_wexp < gew) ? cb_wexp : gew;
    eh = (cb_hexp < geh) ? cb_hexp : geh;
    cgx0 = gx + ((64'(q.prec) % pw) << gew);
    cgy0 = gy + ((64'(q.prec) / pw) << geh);
    prx0 = max64(cgx0, bx0);
    pry0 = max64(cgy0, by0);
    prx1 = min64(cgx0 + (64'd1 << gew), bx1);
    pry1 = min64(cgy0 + (64'd1 << geh), by1);
    cw = (prx0 >= prx1) ? 64'd0 : (up_shift(prx1, ew) - (prx0 >> ew));
    ch = (pry0 >= pry1) ? 64'd0 : (up_shift(pry1, eh) - (pry0 >> eh));
    g.bcols = clamp16(cw);
    g.brows = clamp16(ch);
    if (64'(q.cblk) >= cw * ch) begin
      g.st = cgc_pkg::ST_BLK;
      return g;
    end
    blx = ((prx0 >> ew) << ew) + ((64'(q.cblk) % cw) << ew);
    bly = ((pry0 >> eh) << eh) + ((64'(q.cblk) / cw) << eh);
    brx = min64(blx + (64'd1 << ew), prx1);
    bry = min64(bly + (64'd1 << eh), pry1);
    g.x0 = 32'(max64(blx, prx0));
    g.y0 = 32'(max64(bly, pry0));
    g.x1 = brx[31:0];
    g.y1 = bry[31:0];
    return g;
  endfunction

  // Register write, mirrored into the shadow copy; the caller drops the enable.
  task automatic write_reg(cgc_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      cgc_pkg::REG_TILE_LEFT:   t_left = 64'(val);
      cgc_pkg::REG_TILE_TOP:    t_top = 64'(val);
      cgc_pkg::REG_TILE_RIGHT:  t_right = 64'(val);
      cgc_pkg::REG_TILE_BOTTOM: t_bottom = 64'(val);
      cgc_pkg::REG_NUM_RES:     levels = 32'(val[5:0]);
      cgc_pkg::REG_CBLK_W:      cb_wexp = 32'(val[3:0]);
      default:                  cb_hexp = 32'(val[3:0]);
    endcase
  endtask

  task automatic load_tile(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                           logic [31:0] y1, logic [5:0] nres, logic [3:0] cw,
                           logic [3:0] chh);
    write_reg(cgc_pkg::REG_TILE_LEFT, x0);
    write_reg(cgc_pkg::REG_TILE_TOP, y0);
    write_reg(cgc_pkg::REG_TILE_RIGHT, x1);
    write_reg(cgc_pkg::REG_TILE_BOTTOM, y1);
    write_reg(cgc_pkg::REG_NUM_RES, {26'd0, nres});
    write_reg(cgc_pkg::REG_CBLK_W, {28'd0, cw});
    write_reg(cgc_pkg::REG_CBLK_H, {28'd0, chh});
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every expected word has come back, then lets the pipe drain.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_geom.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Sends one query word, with an optional idle burst first.
  task automatic send_query(query_t q, geom_t exp);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_resolution <= q.res;
    in_subband <= q.band;
    in_precinct_exp_w <= q.pw_exp;
    in_precinct_exp_h <= q.ph_exp;
    in_precinct_index <= q.prec;
    in_codeblock_index <= q.cblk;
    pending_geom.push_back(exp);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic query_t random_query();
    query_t q;
    int unsigned n;
    n = (levels > 33) ? 33 : levels;
    if ($urandom_range(0, 9) == 0) begin
      // Noise: anything the fields allow.
      q.res = 6'($urandom); q.band = 2'($urandom);
      q.pw_exp = 4'($urandom); q.ph_exp = 4'($urandom);
      q.prec = 16'($urandom); q.cblk = 16'($urandom);
    end else begin
      q.res = (n == 0) ? 6'd0 : 6'($urandom_range(0, n - 1));
      q.band = (q.res == 6'd0) ? cgc_pkg::BAND_LL : 2'($urandom_range(0, 2));
      q.pw_exp = 4'($urandom_range(1, 15));
      q.ph_exp = 4'($urandom_range(1, 15));
      q.prec = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
      q.cblk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    end
    return q;
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
      rx_idle <= 0;
    end else if (hold_recv || hold_cycles != 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_recv ? 200 : hold_cycles - 1;
    end else if (rx_idle != 0) begin
      out_ready <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_idle <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checker on accepted result words.
  always @(posedge clk) begin
    geom_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_geom.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word");
      end else begin
        e = pending_geom.pop_front();
        if (out_block_left !== e.x0 || out_block_top !== e.y0 ||
            out_block_right !== e.x1 || out_block_bottom !== e.y1 ||
            out_precincts_wide !== e.pcols || out_precincts_high !== e.prows ||
            out_blocks_wide !== e.bcols || out_blocks_high !== e.brows ||
            out_status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp %h %h %h %h %h %h %h %h %0d got %h %h %h %h %h %h %h %h %0d",
                     e.x0, e.y0, e.x1, e.y1, e.pcols, e.prows, e.bcols, e.brows, e.st,
                     out_block_left, out_block_top, out_block_right, out_block_bottom,
                     out_precincts_wide, out_precincts_high, out_blocks_wide,
                     out_blocks_high, out_status);
        end
      end
    end
  end

  // Directed rows, run with the reset configuration, then a small tile and a huge tile.
  row_t rows[$];

  function automatic query_t mkq(int r, int b, int pw, int ph, int p, int c);
    query_t q;
    q.res = 6'(r); q.band = 2'(b); q.pw_exp = 4'(pw); q.ph_exp = 4'(ph);
    q.prec = 16'(p); q.cblk = 16'(c);
    return q;
  endfunction

  function automatic geom_t status_only(cgc_pkg::status_t s);
    geom_t g;
    g = '{default: '0};
    g.st = s;
    return g;
  endfunction

  // Typed results are what the block must return; other rows use the predictor.
  task automatic run_rows();
    foreach (rows[i]) begin
      send_query(rows[i].q, rows[i].has_fixed ? rows[i].fixed : block_geometry(rows[i].q));
    end
  endtask

  initial begin
    int phase;
    query_t q;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0;
    in_resolution = '0; in_subband = '0; in_precinct_exp_w = '0; in_precinct_exp_h = '0;
    in_precinct_index = '0; in_codeblock_index = '0;
    quiet_phase = 0; hold_recv = 0;
    t_left = 0; t_top = 0; t_right = 0; t_bottom = 0;
    levels = 6; cb_wexp = 6; cb_hexp = 6;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: empty tile, so counts are zero and every precinct is out of range.
    rows.push_back('{mkq(0, 0, 15, 15, 0, 0), 1, status_only(cgc_pkg::ST_PREC)});
    rows.push_back('{mkq(6, 0, 5, 5, 0, 0), 1, status_only(cgc_pkg::ST_BAD)});
    rows.push_back('{mkq(63, 3, 15, 15, 16'hFFFF, 16'hFFFF), 1,
                     status_only(cgc_pkg::ST_BAD)});
    rows.push_back('{mkq(0, 1, 5, 5, 0, 0), 1, status_only(cgc_pkg::ST_BAD)});
    rows.push_back('{mkq(3, 3, 5, 5, 0, 0), 1, status_only(cgc_pkg::ST_BAD)});
    rows.push_back('{mkq(2, 1, 0, 5, 0, 0), 1, status_only(cgc_pkg::ST_BAD)});
    run_rows();
    drain_all();

    // Small tile with the origin below the band offset.
    load_tile(32'd1, 32'd3, 32'd300, 32'd200, 6'd5, 4'd4, 4'd3);
    rows.delete();
    rows.push_back('{mkq(0, 0, 0, 0, 0, 0), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(0, 0, 15, 15, 0, 0), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(1, 0, 1, 1, 0, 0), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(2, 1, 3, 3, 1, 2), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(3, 2, 4, 4, 2, 1), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(4, 2, 15, 15, 0, 3), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(4, 0, 2, 2, 16'hFFFF, 0), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(4, 1, 6, 6, 0, 16'hFFFF), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(3, 0, 5, 5, 3, 0), 0, status_only(cgc_pkg::ST_OK)});
    run_rows();
    drain_all();

    // Huge tile: grid end overflows 32 bits.
    load_tile(32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 4'd15, 4'd0);
    rows.delete();
    rows.push_back('{mkq(32, 0, 15, 15, 0, 0), 1, status_only(cgc_pkg::ST_OVF)});
    rows.push_back('{mkq(32, 2, 1, 1, 0, 0), 0, status_only(cgc_pkg::ST_OK)});
    rows.push_back('{mkq(0, 0, 0, 0, 0, 0), 0, status_only(cgc_pkg::ST_OK)});
    run_rows();
    drain_all();

    // Random phases under a range of configurations.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_tile(32'd0, 32'd0, 32'd2048, 32'd1024, 6'd6, 4'd6, 4'd6);
        1: load_tile(32'd7, 32'd5, 32'd9, 32'd6, 6'd3, 4'd2, 4'd2);
        2: load_tile(32'd500, 32'd400, 32'd100, 32'd80, 6'd4, 4'd10, 4'd10);
        3: load_tile($urandom_range(0, 5000), $urandom_range(0, 5000),
                     $urandom_range(5000, 70000), $urandom_range(5000, 70000),
                     6'($urandom_range(1, 12)), 4'($urandom_range(2, 10)),
                     4'($urandom_range(2, 10)));
        4: load_tile(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd33, 4'd2, 4'd10);
        5: load_tile($urandom, $urandom, $urandom, $urandom, 6'($urandom_range(0, 40)),
                     4'($urandom), 4'($urandom));
        6: load_tile(32'd3, 32'd1, 32'd1000, 32'd700, 6'd8, 4'd5, 4'd4);
        default: load_tile($urandom_range(0, 300), $urandom_range(0, 300),
                           $urandom_range(300, 4000), $urandom_range(300, 4000),
                           6'($urandom_range(1, 10)), 4'($urandom_range(2, 10)),
                           4'($urandom_range(2, 10)));
      endcase
      quiet_phase = (phase == 7);
      for (int k = 0; k < NUM_RANDOM / 8; k++) begin
        // Long receiver hold-off once, while words keep coming.
        if (phase == 1 && k == 20) begin
          in_valid <= 1'b0;
          hold_recv = 1;
          repeat (2) @(posedge clk);
          hold_recv = 0;
        end
        q = random_query();
        send_query(q, block_geometry(q));
      end
      drain_all();
    end

    if (mismatches == 0 && pending_geom.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
